// ===== rtl/core/frl_pkg.sv =====
`default_nettype none

package frl_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned OpW     = 2;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 7;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned PageW   = 5;
  localparam int unsigned CountW  = 6;

  localparam logic [CodeW-1:0] NoAlarm = 8'h00;

  typedef enum logic [OpW-1:0] {
    OpLog   = 2'd0,
    OpErase = 2'd1,
    OpRead  = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  // One stored log entry: 41 bits.
  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } entry_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StExec = 5'b00010,
    StResp = 5'b00100,
    StRead = 5'b01000,
    StData = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/frl_mem.sv =====
`default_nettype none

module frl_mem
  import frl_pkg::*;
#(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire entry_t            wdata_i,
  output entry_t                 rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/frl_ctrl.sv =====
`default_nettype none

module frl_ctrl
  import frl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH    = 32,
  parameter int unsigned PAGE_ENTRIES = 3,
  parameter int unsigned PTR_W        = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire op_e               op_i,
  input  wire entry_t            entry_i,
  input  wire logic [PageW-1:0]  page_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   out_entry_valid_o,
  output entry_t                 out_entry_o,
  output logic [CountW-1:0]      out_count_o,
  output logic [CodeW-1:0]       out_newest_o,
  output logic                   out_last_o,
  output logic                   mem_we_o,
  output logic                   mem_re_o,
  output logic [PTR_W-1:0]       mem_addr_o,
  output entry_t                 mem_wdata_o,
  input  wire entry_t            mem_rdata_i
);

  localparam int unsigned CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned N_W    = $clog2(PAGE_ENTRIES + 1);
  localparam int unsigned SKIP_W = PageW + N_W;
  localparam int unsigned CMP_W  = (SKIP_W > CNT_W) ? SKIP_W : CNT_W;
  localparam int unsigned SUM_W  = CNT_W + 1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(LOG_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  state_e            state_q, state_d;
  op_e               op_q;
  entry_t            entry_q;
  logic [PageW-1:0]  page_q;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  old_ptr_q, old_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CodeW-1:0]  newest_q, newest_d;
  logic [PTR_W-1:0]  rd_addr_q, rd_addr_d;
  logic [N_W-1:0]    rem_q, rem_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ev_q;
  entry_t            out_entry_q;
  logic [CountW-1:0] out_count_q;
  logic [CodeW-1:0]  out_newest_q;
  logic              out_last_q;

  logic              accept;
  logic              out_free;
  logic              load_resp, load_entry;
  logic              is_full;
  logic [PageW-1:0]  page_eff;
  logic [SKIP_W-1:0] skip;
  logic              page_hit;
  logic [CMP_W-1:0]  left;
  logic [N_W-1:0]    run_len;
  logic [SUM_W-1:0]  start_sum;
  logic [PTR_W-1:0]  start_addr;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_resp  = (state_q == StResp) && out_free;
  assign load_entry = (state_q == StData) && out_free;
  assign is_full    = (count_q == CNT_W'(LOG_DEPTH));

  // Page arithmetic: skip from the oldest entry, run length and first address.
  assign page_eff = (page_q == '0) ? PageW'(1) : page_q;
  assign skip     = SKIP_W'(page_eff - PageW'(1)) * SKIP_W'(PAGE_ENTRIES);
  assign page_hit = CMP_W'(skip) < CMP_W'(count_q);
  assign left     = CMP_W'(count_q) - CMP_W'(skip);
  assign run_len  = (left < CMP_W'(PAGE_ENTRIES)) ? N_W'(left) : N_W'(PAGE_ENTRIES);
  // The skip is below the count here, so one conditional subtract wraps the sum.
  assign start_sum  = SUM_W'(old_ptr_q) + SUM_W'(CNT_W'(skip));
  assign start_addr = (start_sum >= SUM_W'(LOG_DEPTH)) ?
                      PTR_W'(start_sum - SUM_W'(LOG_DEPTH)) : PTR_W'(start_sum);

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    old_ptr_d   = old_ptr_q;
    count_d     = count_q;
    newest_d    = newest_q;
    rd_addr_d   = rd_addr_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        state_d = StResp;
        unique case (op_q)
          OpLog: begin
            if (is_full) old_ptr_d = ptr_inc(old_ptr_q);
            else count_d = count_q + CNT_W'(1);
            wr_ptr_d = ptr_inc(wr_ptr_q);
            newest_d = entry_q.code;
          end
          OpErase: begin
            wr_ptr_d  = '0;
            old_ptr_d = '0;
            count_d   = '0;
            newest_d  = NoAlarm;
          end
          OpRead: begin
            if (page_hit) begin
              rd_addr_d = start_addr;
              rem_d     = run_len;
              state_d   = StRead;
            end
          end
          OpRsvd: begin
            state_d = StResp;
          end
          default: state_d = StResp;
        endcase
      end
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StRead: begin
        state_d = StData;
      end
      StData: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rem_d       = rem_q - N_W'(1);
          rd_addr_d   = ptr_inc(rd_addr_q);
          state_d     = (rem_q == N_W'(1)) ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpRsvd;
      wr_ptr_q    <= '0;
      old_ptr_q   <= '0;
      count_q     <= '0;
      newest_q    <= NoAlarm;
      rd_addr_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (accept) op_q <= op_i;
      wr_ptr_q    <= wr_ptr_d;
      old_ptr_q   <= old_ptr_d;
      count_q     <= count_d;
      newest_q    <= newest_d;
      rd_addr_q   <= rd_addr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_i;
      page_q  <= page_i;
    end
    if (load_resp || load_entry) begin
      out_ev_q     <= load_entry;
      out_entry_q  <= load_entry ? mem_rdata_i : '0;
    end
  end

  // Count and newest code do not change during a run, so they are sampled
  // together with the payload.
  always_ff @(posedge clk_i) begin
    if (load_resp || load_entry) begin
      out_count_q  <= CountW'(count_q);
      out_newest_q <= newest_q;
      out_last_q   <= load_resp || (rem_q == N_W'(1));
    end
  end

  assign mem_we_o    = (state_q == StExec) && (op_q == OpLog);
  assign mem_re_o    = (state_q == StRead);
  assign mem_addr_o  = (state_q == StRead) ? rd_addr_q : wr_ptr_q;
  assign mem_wdata_o = entry_q;

  assign out_valid_o       = out_valid_q;
  assign out_entry_valid_o = out_ev_q;
  assign out_entry_o       = out_entry_q;
  assign out_count_o       = out_count_q;
  assign out_newest_o      = out_newest_q;
  assign out_last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/timestamped_fault_ring_log_unit.sv =====
`default_nettype none

// Ring log of timestamped fault codes held in a single-port synchronous memory of LOG_DEPTH
// entries. A log request stores the code and stamp at the write pointer and overwrites the
// oldest entry once the log is full; an erase request empties the log; a page read returns up
// to PAGE_ENTRIES entries, oldest first, after skipping earlier pages, with last_of_run set on
// the final one. Log, erase, unused-code and page-past-end requests pass through the Exec and
// Resp states from accept to result. A page read passes through Exec, then Read and Data for
// each entry, as each entry is one read of the memory port with registered read data. Result
// stalls hold it in Resp or Data. After erase or reset the memory is not cleared: only entries
// written since then are ever read, so the block is ready right out of reset.
module timestamped_fault_ring_log_unit
  import frl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH    = 32,
  parameter int unsigned PAGE_ENTRIES = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OpW-1:0]     operation_i,
  input  wire logic [CodeW-1:0]   fault_code_i,
  input  wire logic [DayW-1:0]    stamp_day_i,
  input  wire logic [MonthW-1:0]  stamp_month_i,
  input  wire logic [YearW-1:0]   stamp_year_i,
  input  wire logic [HourW-1:0]   stamp_hour_i,
  input  wire logic [MinuteW-1:0] stamp_minute_i,
  input  wire logic [SecondW-1:0] stamp_second_i,
  input  wire logic [PageW-1:0]   page_number_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    entry_valid_o,
  output logic [CodeW-1:0]        entry_code_o,
  output logic [DayW-1:0]         entry_day_o,
  output logic [MonthW-1:0]       entry_month_o,
  output logic [YearW-1:0]        entry_year_o,
  output logic [HourW-1:0]        entry_hour_o,
  output logic [MinuteW-1:0]      entry_minute_o,
  output logic [SecondW-1:0]      entry_second_o,
  output logic [CountW-1:0]       entry_count_o,
  output logic [CodeW-1:0]        newest_code_o,
  output logic                    last_of_run_o
);

  localparam int unsigned PTR_W = $clog2(LOG_DEPTH);

  entry_t            in_entry;
  entry_t            out_entry;
  logic              mem_we;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_addr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  assign in_entry = '{
    code:   fault_code_i,
    day:    stamp_day_i,
    month:  stamp_month_i,
    year:   stamp_year_i,
    hour:   stamp_hour_i,
    minute: stamp_minute_i,
    second: stamp_second_i
  };

  frl_ctrl #(
    .LOG_DEPTH    (LOG_DEPTH),
    .PAGE_ENTRIES (PAGE_ENTRIES),
    .PTR_W        (PTR_W)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_e'(operation_i)),
    .entry_i           (in_entry),
    .page_i            (page_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_entry_valid_o (entry_valid_o),
    .out_entry_o       (out_entry),
    .out_count_o       (entry_count_o),
    .out_newest_o      (newest_code_o),
    .out_last_o        (last_of_run_o),
    .mem_we_o          (mem_we),
    .mem_re_o          (mem_re),
    .mem_addr_o        (mem_addr),
    .mem_wdata_o       (mem_wdata),
    .mem_rdata_i       (mem_rdata)
  );

  frl_mem #(
    .DEPTH  (LOG_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign entry_code_o   = out_entry.code;
  assign entry_day_o    = out_entry.day;
  assign entry_month_o  = out_entry.month;
  assign entry_year_o   = out_entry.year;
  assign entry_hour_o   = out_entry.hour;
  assign entry_minute_o = out_entry.minute;
  assign entry_second_o = out_entry.second;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import frl_pkg::*;

  localparam int LOG_DEPTH      = 32;
  localparam int PAGE_ENTRIES   = 3;
  localparam int RANDOM_TARGET  = 210;
  localparam int HOLD_AFTER     = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    op_e              op;
    entry_t           fault;
    logic [PageW-1:0] page;
    int               gap;
  } request_t;

  typedef struct {
    logic              has_entry;
    entry_t            entry;
    logic [CountW-1:0] count;
    logic [CodeW-1:0]  newest;
    logic              last_flag;
  } log_result_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      operation_i    = '0;
  logic [CodeW-1:0]    fault_code_i   = '0;
  logic [DayW-1:0]     stamp_day_i    = '0;
  logic [MonthW-1:0]   stamp_month_i  = '0;
  logic [YearW-1:0]    stamp_year_i   = '0;
  logic [HourW-1:0]    stamp_hour_i   = '0;
  logic [MinuteW-1:0]  stamp_minute_i = '0;
  logic [SecondW-1:0]  stamp_second_i = '0;
  logic [PageW-1:0]    page_number_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                entry_valid_o;
  logic [CodeW-1:0]    entry_code_o;
  logic [DayW-1:0]     entry_day_o;
  logic [MonthW-1:0]   entry_month_o;
  logic [YearW-1:0]    entry_year_o;
  logic [HourW-1:0]    entry_hour_o;
  logic [MinuteW-1:0]  entry_minute_o;
  logic [SecondW-1:0]  entry_second_o;
  logic [CountW-1:0]   entry_count_o;
  logic [CodeW-1:0]    newest_code_o;
  logic                last_of_run_o;

  timestamped_fault_ring_log_unit #(
    .LOG_DEPTH   (LOG_DEPTH),
    .PAGE_ENTRIES(PAGE_ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .fault_code_i  (fault_code_i),
    .stamp_day_i   (stamp_day_i),
    .stamp_month_i (stamp_month_i),
    .stamp_year_i  (stamp_year_i),
    .stamp_hour_i  (stamp_hour_i),
    .stamp_minute_i(stamp_minute_i),
    .stamp_second_i(stamp_second_i),
    .page_number_i (page_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_valid_o (entry_valid_o),
    .entry_code_o  (entry_code_o),
    .entry_day_o   (entry_day_o),
    .entry_month_o (entry_month_o),
    .entry_year_o  (entry_year_o),
    .entry_hour_o  (entry_hour_o),
    .entry_minute_o(entry_minute_o),
    .entry_second_o(entry_second_o),
    .entry_count_o (entry_count_o),
    .newest_code_o (newest_code_o),
    .last_of_run_o (last_of_run_o)
  );

  // Predicted log contents and ring pointers.
  entry_t      ring [LOG_DEPTH] = '{default: '0};
  logic [4:0]  wr_ptr     = '0;
  logic [4:0]  old_ptr    = '0;
  bit          ring_empty = 1'b1;
  bit          ring_full  = 1'b0;

  request_t    request_queue [$];
  log_result_t pending_results [$];
  int          total_requests    = 0;
  int          accepted_requests = 0;
  int          mismatches        = 0;
  int          send_calm         = 0;
  int          recv_calm         = 0;

  request_t    next_req;
  request_t    bus_req;
  bit          next_ready = 1'b0;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  int          idle_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Draws a per-request wait, with occasional stretches of no waiting at all.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic request_t make_request(op_e op);
    request_t r;
    r.op           = op;
    r.fault.code   = CodeW'($urandom);
    r.fault.day    = DayW'($urandom);
    r.fault.month  = MonthW'($urandom);
    r.fault.year   = YearW'($urandom);
    r.fault.hour   = HourW'($urandom);
    r.fault.minute = MinuteW'($urandom);
    r.fault.second = SecondW'($urandom);
    r.page         = PageW'($urandom);
    r.gap          = draw_wait(send_calm);
    return r;
  endfunction

  function automatic void add_request(request_t r);
    request_queue.push_back(r);
    total_requests++;
  endfunction

  function automatic int held_entries();
    logic [4:0] span;
    if (ring_full) return LOG_DEPTH;
    if (ring_empty) return 0;
    span = wr_ptr - old_ptr;
    return span;
  endfunction

  function automatic logic [CodeW-1:0] newest_code();
    logic [4:0] idx;
    if (ring_empty) return NoAlarm;
    idx = wr_ptr - 5'd1;
    return ring[idx].code;
  endfunction

  // Every result reports the occupancy and newest code after the request.
  function automatic void push_result(logic has_entry, entry_t e, logic last_flag);
    log_result_t r;
    r.has_entry = has_entry;
    r.entry     = has_entry ? e : '0;
    r.count     = CountW'(held_entries());
    r.newest    = newest_code();
    r.last_flag = last_flag;
    pending_results.push_back(r);
  endfunction

  task automatic predict_log_results(request_t r);
    int         page;
    int         skip;
    int         avail;
    int         n;
    int         k;
    logic [4:0] idx;
    case (r.op)
      OpLog: begin
        ring[wr_ptr] = r.fault;
        if (ring_full) old_ptr = old_ptr + 5'd1;
        wr_ptr = wr_ptr + 5'd1;
        ring_empty = 1'b0;
        if (wr_ptr == old_ptr) ring_full = 1'b1;
        push_result(1'b0, '0, 1'b1);
      end
      OpErase: begin
        foreach (ring[i]) ring[i] = '0;
        wr_ptr     = '0;
        old_ptr    = '0;
        ring_empty = 1'b1;
        ring_full  = 1'b0;
        push_result(1'b0, '0, 1'b1);
      end
      OpRead: begin
        page  = (r.page == 0) ? 1 : int'(r.page);
        skip  = (page - 1) * PAGE_ENTRIES;
        avail = held_entries();
        if (skip < avail) begin
          n = (avail - skip < PAGE_ENTRIES) ? avail - skip : PAGE_ENTRIES;
          for (k = 0; k < n; k++) begin
            idx = 5'(int'(old_ptr) + skip + k);
            push_result(1'b1, ring[idx], k == n - 1);
          end
        end else begin
          push_result(1'b0, '0, 1'b1);
        end
      end
      default: push_result(1'b0, '0, 1'b1);
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: waits out each request's gap, then holds it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        predict_log_results(bus_req);
        accepted_requests <= accepted_requests + 1;
      end
      if (!next_ready && request_queue.size() > 0) begin
        next_req   = request_queue.pop_front();
        gap_left   = next_req.gap;
        next_ready = 1'b1;
      end
      if (next_ready && gap_left == 0) begin
        bus_req        = next_req;
        next_ready     = 1'b0;
        operation_i    <= next_req.op;
        fault_code_i   <= next_req.fault.code;
        stamp_day_i    <= next_req.fault.day;
        stamp_month_i  <= next_req.fault.month;
        stamp_year_i   <= next_req.fault.year;
        stamp_hour_i   <= next_req.fault.hour;
        stamp_minute_i <= next_req.fault.minute;
        stamp_second_i <= next_req.fault.second;
        page_number_i  <= next_req.page;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (next_ready) gap_left--;
      end
    end
  end

  // Result monitor with random stalls and one long hold-off to back up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    log_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("entry_valid", want.has_entry, entry_valid_o);
          check_field("entry_code", want.entry.code, entry_code_o);
          check_field("entry_day", want.entry.day, entry_day_o);
          check_field("entry_month", want.entry.month, entry_month_o);
          check_field("entry_year", want.entry.year, entry_year_o);
          check_field("entry_hour", want.entry.hour, entry_hour_o);
          check_field("entry_minute", want.entry.minute, entry_minute_o);
          check_field("entry_second", want.entry.second, entry_second_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("newest_code", want.newest, newest_code_o);
          check_field("last_of_run", want.last_flag, last_of_run_o);
        end
        stall_left = draw_wait(recv_calm);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      if (!hold_done && accepted_requests >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_stall_i <= (stall_left > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[timestamped_fault_ring_log_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    request_t r;
    int       n_logs;
    int       n_reads;

    // Reads and the unused code on an empty log.
    r = make_request(OpRead);  r.page = 1;       add_request(r);
    r = make_request(OpRsvd);                    add_request(r);
    // Extremes of the code and stamp fields, including the no-alarm code.
    r = make_request(OpLog);   r.fault = '1;     add_request(r);
    r = make_request(OpLog);   r.fault = '0;     add_request(r);
    r = make_request(OpLog);                     add_request(r);
    // Page zero reads as page one; page two is just past the end.
    r = make_request(OpRead);  r.page = 0;       add_request(r);
    r = make_request(OpRead);  r.page = 1;       add_request(r);
    r = make_request(OpRead);  r.page = 2;       add_request(r);
    r = make_request(OpLog);                     add_request(r);
    r = make_request(OpLog);                     add_request(r);
    r = make_request(OpRead);  r.page = 2;       add_request(r);
    r = make_request(OpRead);  r.page = '1;      add_request(r);
    r = make_request(OpRsvd);                    add_request(r);
    r = make_request(OpErase);                   add_request(r);
    r = make_request(OpRead);  r.page = 1;       add_request(r);
    r = make_request(OpLog);                     add_request(r);
    r = make_request(OpRead);  r.page = 1;       add_request(r);

    // Random phases: optional erase, a burst of faults, then page reads.
    // Long bursts fill the ring so that wrap and overwrite get exercised.
    while (total_requests < RANDOM_TARGET) begin
      if ($urandom_range(0, 3) == 0) add_request(make_request(OpErase));
      n_logs = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 10);
      repeat (n_logs) add_request(make_request(OpLog));
      n_reads = $urandom_range(1, 5);
      repeat (n_reads) begin
        if ($urandom_range(0, 7) == 0) begin
          r = make_request(OpRsvd);
        end else begin
          r = make_request(OpRead);
          if ($urandom_range(0, 3) != 0) r.page = PageW'($urandom_range(0, 12));
        end
        add_request(r);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_requests != total_requests) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[timestamped_fault_ring_log_unit] OK");
    end else begin
      $display("[timestamped_fault_ring_log_unit] ERROR");
    end
    $finish;
  end

endmodule
